[hw/rtl/slw_pkg.sv]
package slw_pkg;

    // Field widths fixed by the track format.
    localparam int START_W    = 20;
    localparam int END_W      = 21;
    localparam int OUT_ADDR_W = 20;
    localparam int TICK_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int REP_W      = 16;
    localparam int MEAS_W     = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 112;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_END   = 1'b1;

    // Control command bytes.
    localparam logic [BYTE_W-1:0] CMD_LOOP_END    = 8'hF8;
    localparam logic [BYTE_W-1:0] CMD_LOOP_START  = 8'hF9;
    localparam logic [BYTE_W-1:0] CMD_REPEAT      = 8'hFC;
    localparam logic [BYTE_W-1:0] CMD_MEASURE_END = 8'hFD;
    localparam logic [BYTE_W-1:0] CMD_TRACK_END   = 8'hFE;

    localparam logic [START_W-1:0] START_RESET = 20'd16;
    localparam logic [END_W-1:0]   END_RESET   = 21'd0;
    localparam logic [MEAS_W-1:0]  NO_MEASURE  = 9'h1FF;
    localparam logic [BYTE_W-1:0]  HEADER_SIZE = 8'h08;
    localparam logic [BYTE_W-1:0]  WORD_SIZE   = 8'h04;
    localparam logic [BYTE_W-1:0]  REPEAT_BIAS = 8'h24;

endpackage

[hw/rtl/sequence_loop_walker_top.sv]
// Channel  | Direction | tdata (lowest bit up)                           | tuser
// ---------+-----------+-------------------------------------------------+---------
// s_       | in        | cmd_type, delay_byte, param_one, param_two      | restart
// m_       | out       | next_addr, finished, tick_total, loop_offset,   | -
//          |           | loop_tick_mark, zero fill to 112 bits           |
// cfg_     | in        | cfg_wdata: track_start_addr or track_end_addr   | -
//
// Each beat passes an input register and a result register. Its result is
// loaded into the result register as it leaves the input register, which
// waits while a held result is not taken. A new beat is taken every cycle while
// m_tready stays high. In a fetch loop the next command word is read at
// next_addr, so the item rate is set by the memory read round trip.
// aresetn is synchronous and active low; the block comes out of reset
// finished, so commands before the first restart only repeat the state.
// When m_tready is low the result holds and one more beat is still taken
// into the input register; s_tready then drops until the result moves on.
module sequence_loop_walker_top #(
    parameter int LOOP_DEPTH = 8,
    parameter int ADDR_BITS  = 20
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write port.
    input  logic                           cfg_we,
    input  logic [slw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [slw_pkg::END_W-1:0]      cfg_wdata,
    // Command beats.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [slw_pkg::IN_DATA_W-1:0]  s_tdata,  // cmd_type, delay_byte, param_one, param_two
    input  logic                           s_tuser,  // restart
    // Result beats.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [slw_pkg::OUT_DATA_W-1:0] m_tdata   // next_addr, finished, tick_total,
                                                     // loop_offset, loop_tick_mark, zeros
);

    import slw_pkg::*;

    localparam int AW = ADDR_BITS;
    // Wide enough for every sum and compare against the 21-bit end address.
    localparam int XW = ((ADDR_BITS > END_W) ? ADDR_BITS : END_W) + 1;
    localparam int DW = $clog2(LOOP_DEPTH + 1);
    localparam int IW = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;
    localparam int PAD_W = OUT_DATA_W - (2 * OUT_ADDR_W + 2 * TICK_W + 1);

    // Configuration registers.
    logic [START_W-1:0] start_reg;
    logic [END_W-1:0]   end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= START_RESET;
            end_reg   <= END_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_TRACK_START: start_reg <= cfg_wdata[START_W-1:0];
                REG_TRACK_END:   end_reg   <= cfg_wdata;
                default:         end_reg   <= end_reg;
            endcase
        end
    end

    // Input register.
    logic              in_valid_reg;
    logic              in_restart_reg;
    logic [BYTE_W-1:0] in_cmd_reg;
    logic [BYTE_W-1:0] in_delay_reg;
    logic [BYTE_W-1:0] in_p1_reg;
    logic [BYTE_W-1:0] in_p2_reg;

    // Result register.
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic fire;
    logic s_accept;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_restart_reg <= s_tuser;
            in_cmd_reg     <= s_tdata[7:0];
            in_delay_reg   <= s_tdata[15:8];
            in_p1_reg      <= s_tdata[23:16];
            in_p2_reg      <= s_tdata[31:24];
        end
    end

    // Walker state.
    logic [AW-1:0]     pos_reg,       pos_next;
    logic [AW-1:0]     ret_reg,       ret_next;
    logic [MEAS_W-1:0] meas_reg,      meas_next;
    logic [DW-1:0]     depth_reg,     depth_next;
    logic [TICK_W-1:0] tick_reg,      tick_next;
    logic [AW-1:0]     loop_off_reg,  loop_off_next;
    logic [TICK_W-1:0] loop_tick_reg, loop_tick_next;
    logic              done_reg,      done_next;

    // Loop frames; only frames below the depth are ever read.
    logic [AW-1:0]     stack_parent_reg [LOOP_DEPTH];
    logic [AW-1:0]     stack_pos_reg    [LOOP_DEPTH];
    logic [TICK_W-1:0] stack_tick_reg   [LOOP_DEPTH];
    logic [BYTE_W-1:0] stack_count_reg  [LOOP_DEPTH];

    logic [DW-1:0]     depth_m1;
    logic [IW-1:0]     top_idx;
    logic [IW-1:0]     push_idx;
    logic [BYTE_W-1:0] cnt_inc;
    logic [XW-1:0]     end_x;
    logic [XW-1:0]     first_x;
    logic [XW-1:0]     advanced_x;
    logic [XW-1:0]     rep_x;
    logic [AW-1:0]     advanced;
    logic [REP_W-1:0]  rep;
    logic              push_en;
    logic              cnt_we;

    assign depth_m1   = depth_reg - DW'(1);
    assign top_idx    = depth_m1[IW-1:0];
    assign push_idx   = depth_reg[IW-1:0];
    assign cnt_inc    = stack_count_reg[top_idx] + 8'd1;
    assign end_x      = XW'(end_reg);
    assign first_x    = XW'(start_reg) + XW'(HEADER_SIZE);
    assign advanced_x = XW'(pos_reg) + XW'(WORD_SIZE);
    assign advanced   = advanced_x[AW-1:0];
    assign rep        = {in_p2_reg, in_p1_reg};
    assign rep_x      = XW'(start_reg) + XW'(rep) - XW'(REPEAT_BIAS);

    always_comb begin
        pos_next       = pos_reg;
        ret_next       = ret_reg;
        meas_next      = meas_reg;
        depth_next     = depth_reg;
        tick_next      = tick_reg;
        loop_off_next  = loop_off_reg;
        loop_tick_next = loop_tick_reg;
        done_next      = done_reg;
        push_en        = 1'b0;
        cnt_we         = 1'b0;

        if (in_restart_reg) begin
            pos_next       = first_x[AW-1:0];
            ret_next       = '0;
            meas_next      = NO_MEASURE;
            depth_next     = '0;
            tick_next      = '0;
            loop_off_next  = '0;
            loop_tick_next = '0;
            done_next      = (first_x >= end_x);
        end else if (!done_reg) begin
            // Step over this word; a carry out of the address counts as past the end.
            pos_next = advanced;
            if (advanced_x[AW] || (XW'(advanced) >= end_x)) begin
                done_next = 1'b1;
            end

            case (in_cmd_reg)
                CMD_LOOP_END: begin
                    if (depth_reg != '0) begin
                        depth_next = depth_m1;
                        cnt_we     = 1'b1;
                        if (in_delay_reg == '0) begin
                            // Infinite loop: the walk ends and the loop point is kept.
                            loop_off_next  = stack_pos_reg[top_idx];
                            loop_tick_next = stack_tick_reg[top_idx];
                            done_next      = 1'b1;
                        end else if (cnt_inc < in_delay_reg) begin
                            ret_next   = stack_parent_reg[top_idx];
                            depth_next = depth_reg;
                            pos_next   = stack_pos_reg[top_idx];
                            done_next  = (XW'(stack_pos_reg[top_idx]) >= end_x);
                        end
                    end
                end
                CMD_LOOP_START: begin
                    // A full stack, or a restart of the loop already on top, leaves the stack unchanged.
                    if (depth_reg < DW'(LOOP_DEPTH)) begin
                        if (!((depth_reg != '0) && (stack_pos_reg[top_idx] == advanced))) begin
                            push_en    = 1'b1;
                            depth_next = depth_reg + DW'(1);
                        end
                    end
                end
                CMD_REPEAT: begin
                    // The measure that is already repeating is not entered again.
                    if ({1'b0, in_delay_reg} != meas_reg) begin
                        if (ret_reg == '0) begin
                            ret_next = advanced;
                        end
                        meas_next = {1'b0, in_delay_reg};
                        pos_next  = rep_x[AW-1:0];
                        done_next = (XW'(rep_x[AW-1:0]) >= end_x);
                    end
                end
                CMD_MEASURE_END: begin
                    if (ret_reg != '0) begin
                        ret_next  = '0;
                        meas_next = NO_MEASURE;
                        pos_next  = ret_reg;
                        done_next = (XW'(ret_reg) >= end_x);
                    end
                end
                CMD_TRACK_END: begin
                    done_next = 1'b1;
                end
                default: begin
                    tick_next = tick_reg + TICK_W'(in_delay_reg);
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            ret_reg       <= '0;
            meas_reg      <= NO_MEASURE;
            depth_reg     <= '0;
            tick_reg      <= '0;
            loop_off_reg  <= '0;
            loop_tick_reg <= '0;
            done_reg      <= 1'b1;
        end else if (fire) begin
            pos_reg       <= pos_next;
            ret_reg       <= ret_next;
            meas_reg      <= meas_next;
            depth_reg     <= depth_next;
            tick_reg      <= tick_next;
            loop_off_reg  <= loop_off_next;
            loop_tick_reg <= loop_tick_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && push_en) begin
            stack_parent_reg[push_idx] <= ret_reg;
            stack_pos_reg[push_idx]    <= advanced;
            stack_tick_reg[push_idx]   <= tick_reg;
            stack_count_reg[push_idx]  <= '0;
        end
        if (fire && cnt_we) begin
            stack_count_reg[top_idx] <= cnt_inc;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= {{PAD_W{1'b0}}, loop_tick_next, OUT_ADDR_W'(loop_off_next),
                             tick_next, done_next, OUT_ADDR_W'(pos_next)};
        end
    end

    // The loop stack never grows past its depth.
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DW'(LOOP_DEPTH))
        else $error("loop stack depth out of range");

    // A command taken after the walk ended leaves the walk untouched.
    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !in_restart_reg && done_reg) |=>
            ($stable(tick_reg) && $stable(pos_reg) && $stable(depth_reg) && done_reg))
        else $error("state changed after the walk finished");

    // A restart clears the stack, the pending return and the tick count.
    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_restart_reg) |=>
            ((depth_reg == '0) && (ret_reg == '0) && (tick_reg == '0)))
        else $error("restart left stale walk state");

    // Input backpressure only comes from a held result with a full input register.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && m_tvalid && !m_tready))
        else $error("input stalled without downstream backpressure");

endmodule
